>>> rtl/rvpc_pkg.sv
// Shared types and codes for the response vote presence checker.
package rvpc_pkg;

    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_FAIL   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic KIND_ATTEMPT = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] VERDICT_ABSENT       = 2'd0;
    localparam logic [1:0] VERDICT_PRESENT      = 2'd1;
    localparam logic [1:0] VERDICT_INCONSISTENT = 2'd2;
    localparam logic [1:0] VERDICT_NO_DATA      = 2'd3;

    localparam logic [7:0] TALLY_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [7:0] pattern;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] vote_byte;
        logic       all_match;
        logic       last_match;
        logic       second_match;
        logic       vote_match;
        logic [1:0] verdict;
        logic [7:0] attempt_total;
        logic [7:0] transport_total;
        logic [7:0] vote_total;
        logic [7:0] second_total;
        logic [7:0] whole_total;
    } out_item_t;

    // Status of a block that completes on the current item.
    typedef struct packed {
        logic       done;
        logic [7:0] vote_byte;
        logic       whole;
        logic       last;
        logic       second;
        logic       vote_match;
    } attempt_t;

    typedef struct packed {
        logic [7:0] attempt;
        logic [7:0] transport;
        logic [7:0] vote;
        logic [7:0] second;
        logic [7:0] whole;
    } tally_t;

endpackage

>>> rtl/rvpc_block_acc.sv
// Per-block accumulator: bit-wise ones counters, byte position and match flags.
module rvpc_block_acc
    import rvpc_pkg::*;
#(
    parameter int BLOCK_BYTES = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    input  logic [7:0] pattern,
    output attempt_t   status
);

    localparam int CW = $clog2(BLOCK_BYTES + 1);
    localparam int PW = $clog2(BLOCK_BYTES);
    localparam logic [PW-1:0] LAST_POS = PW'(BLOCK_BYTES - 1);
    localparam logic [PW-1:0] SECOND_POS = PW'(1);
    localparam logic [CW-1:0] HALF = CW'(BLOCK_BYTES / 2);

    logic [CW-1:0] ones_reg [8];
    logic [CW-1:0] ones_next [8];
    logic [CW-1:0] ones_sum [8];
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          whole_reg;
    logic          whole_next;
    logic          second_reg;
    logic          second_next;

    logic       is_byte;
    logic       at_last;
    logic       match;
    logic       whole_now;
    logic       second_now;
    logic [7:0] expect_byte;
    logic [7:0] vote;
    logic       clear;

    always_comb
    begin
        expect_byte = ~pattern;
        match       = (data_byte == expect_byte);
        is_byte     = step && (opcode == OP_BYTE);
        at_last     = (pos_reg == LAST_POS);
        whole_now   = whole_reg && match;
        second_now  = (pos_reg == SECOND_POS) ? match : second_reg;
        for (int b = 0; b < 8; b++)
        begin
            ones_sum[b] = ones_reg[b] + CW'(data_byte[b]);
            vote[b]     = (ones_sum[b] > HALF);
        end
        // Failure, finish and block end all drop the partial block.
        clear = step && ((opcode == OP_FAIL) || (opcode == OP_FINISH) || (is_byte && at_last));

        ones_next   = ones_reg;
        pos_next    = pos_reg;
        whole_next  = whole_reg;
        second_next = second_reg;
        if (clear)
        begin
            for (int b = 0; b < 8; b++)
            begin
                ones_next[b] = '0;
            end
            pos_next    = '0;
            whole_next  = 1'b1;
            second_next = 1'b0;
        end
        else if (is_byte)
        begin
            ones_next   = ones_sum;
            pos_next    = pos_reg + PW'(1);
            whole_next  = whole_now;
            second_next = second_now;
        end

        status.done       = is_byte && at_last;
        status.vote_byte  = vote;
        status.whole      = whole_now;
        status.last       = match;
        status.second     = second_now;
        status.vote_match = (vote == expect_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 8; b++)
            begin
                ones_reg[b] <= '0;
            end
            pos_reg    <= '0;
            whole_reg  <= 1'b1;
            second_reg <= 1'b0;
        end
        else
        begin
            ones_reg   <= ones_next;
            pos_reg    <= pos_next;
            whole_reg  <= whole_next;
            second_reg <= second_next;
        end
    end

endmodule

>>> rtl/rvpc_tally.sv
// Saturating attempt tallies and presence verdict.
module rvpc_tally
    import rvpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [1:0] opcode,
    input  attempt_t   status,
    output tally_t     totals,
    output logic [1:0] verdict
);

    tally_t cnt_reg;
    tally_t cnt_next;
    logic   is_fail;
    logic   is_finish;

    function automatic logic [7:0] sat_inc(input logic [7:0] v, input logic by);
        logic [7:0] r;
        r = v;
        if (by && (v != TALLY_MAX))
        begin
            r = v + 8'd1;
        end
        return r;
    endfunction

    always_comb
    begin
        is_fail   = step && (opcode == OP_FAIL);
        is_finish = step && (opcode == OP_FINISH);

        cnt_next = cnt_reg;
        if (is_finish)
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next.attempt   = sat_inc(cnt_reg.attempt, status.done || is_fail);
            cnt_next.transport = sat_inc(cnt_reg.transport, status.done);
            cnt_next.vote      = sat_inc(cnt_reg.vote, status.done && status.vote_match);
            cnt_next.second    = sat_inc(cnt_reg.second, status.done && status.second);
            cnt_next.whole     = sat_inc(cnt_reg.whole, status.done && status.whole);
        end

        totals = cnt_reg;
        if (cnt_reg.attempt == 8'd0)
        begin
            verdict = VERDICT_NO_DATA;
        end
        else if (cnt_reg.transport != cnt_reg.attempt)
        begin
            verdict = VERDICT_INCONSISTENT;
        end
        else if ((cnt_reg.vote == cnt_reg.attempt) && (cnt_reg.second == cnt_reg.attempt))
        begin
            verdict = VERDICT_PRESENT;
        end
        else if ((cnt_reg.vote == 8'd0) && (cnt_reg.second == 8'd0))
        begin
            verdict = VERDICT_ABSENT;
        end
        else
        begin
            verdict = VERDICT_INCONSISTENT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/response_vote_presence_checker_core.sv
// Top level of the response vote presence checker: input stage, datapath, report register.
//
// Channels: resp_* carries one item per handshake (response byte, transfer
// failure or finish); rpt_* carries reports. An item moves when valid is high
// and stall is low at a rising edge of clk.
// Each response byte updates eight per-bit ones counters; the last byte of a
// block of BLOCK_BYTES bytes yields an attempt report (majority byte and match
// flags). A finish item yields a verdict report with the saturating tallies
// and clears them. Failures and other bytes yield no report.
// A report comes from the item in the input register and is held in the report register.
// Throughput: one item per cycle unless the report is stalled; the input register and the
// report register are the only pipeline stages, with all per-item work between them.
// Reset (rst_n low, asynchronous): both stages empty, block and tallies clear.
// When the receiver stalls, the report holds; one more item can wait in the
// input register, after which resp_stall rises until the report is taken.
module response_vote_presence_checker_core
    import rvpc_pkg::*;
#(
    parameter int BLOCK_BYTES = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      resp_valid,
    output logic      resp_stall,
    input  in_item_t  resp_item,
    output logic      rpt_valid,
    input  logic      rpt_stall,
    output out_item_t rpt_item
);

    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic       advance;
    logic       step;
    logic       resp_take;
    attempt_t   status;
    tally_t     totals;
    logic [1:0] verdict;

    always_comb
    begin
        advance    = !out_valid_reg || !rpt_stall;
        step       = in_valid_reg && advance;
        resp_stall = in_valid_reg && !advance;
        resp_take  = resp_valid && !resp_stall;
    end

    rvpc_block_acc #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_block (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .opcode   (in_item_reg.opcode),
        .data_byte(in_item_reg.data_byte),
        .pattern  (in_item_reg.pattern),
        .status   (status)
    );

    rvpc_tally u_tally (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .opcode (in_item_reg.opcode),
        .status (status),
        .totals (totals),
        .verdict(verdict)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (resp_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_item_next = '0;
        if (in_item_reg.opcode == OP_FINISH)
        begin
            out_item_next.kind            = KIND_VERDICT;
            out_item_next.verdict         = verdict;
            out_item_next.attempt_total   = totals.attempt;
            out_item_next.transport_total = totals.transport;
            out_item_next.vote_total      = totals.vote;
            out_item_next.second_total    = totals.second;
            out_item_next.whole_total     = totals.whole;
        end
        else
        begin
            out_item_next.kind         = KIND_ATTEMPT;
            out_item_next.vote_byte    = status.vote_byte;
            out_item_next.all_match    = status.whole;
            out_item_next.last_match   = status.last;
            out_item_next.second_match = status.second;
            out_item_next.vote_match   = status.vote_match;
        end

        // Hold the report while stalled; otherwise load whatever this item yields.
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = step && (status.done || (in_item_reg.opcode == OP_FINISH));
        end

        rpt_valid = out_valid_reg;
        rpt_item  = out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_take)
        begin
            in_item_reg <= resp_item;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    a_transport_le_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && (rpt_item.kind == KIND_VERDICT)
        |-> rpt_item.transport_total <= rpt_item.attempt_total)
        else $error("transport tally exceeds attempt tally");

    a_present_needs_votes: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && (rpt_item.kind == KIND_VERDICT) && (rpt_item.verdict == VERDICT_PRESENT)
        |-> (rpt_item.attempt_total != 8'd0) && (rpt_item.vote_total == rpt_item.attempt_total))
        else $error("present verdict without full vote tally");

    a_whole_implies_last: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && (rpt_item.kind == KIND_ATTEMPT) && rpt_item.all_match
        |-> rpt_item.last_match)
        else $error("whole-block match without last-byte match");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        resp_stall |-> in_valid_reg && rpt_valid)
        else $error("input stalled with a free pipeline");

endmodule
